@@ rtl/cdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cdfs_pkg
// Shared constants and types for the weighted index sampler: field widths,
// item codes and the sequencer states.
// ----------------------------------------------------------------------------
package cdfs_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int WEIGHT_BITS = 32;
	localparam int FRAC_BITS   = 24;

	localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS;
	localparam int REM_BITS   = TOTAL_BITS + 1;
	localparam int PROB_BITS  = FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(FRAC_BITS + 1);
	localparam int MODE_BITS  = 2;

	localparam logic [PROB_BITS-1:0] ONE_FIX = PROB_BITS'(1) << FRAC_BITS;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_FINISH = 2'd1,
		MODE_SAMPLE = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIN_RD,
		ST_FIN_INIT,
		ST_FIN_DIV,
		ST_FIN_WR,
		ST_SRCH,
		ST_SRCH_CMP,
		ST_PICK_RD,
		ST_PICK_OUT
	} state_t;

endpackage

@@ rtl/cdfs_if.sv @@
// ----------------------------------------------------------------------------
// cdfs_req_if / cdfs_rsp_if
// Valid/ready channels of the sampler: request items in, result items out.
// ----------------------------------------------------------------------------
interface cdfs_req_if;
	import cdfs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [MODE_BITS-1:0]       mode;
	logic [WEIGHT_BITS-1:0]     weight;
	logic [FRAC_BITS-1:0]       choice;

	modport source (output valid, mode, weight, choice, input ready);
	modport sink   (input valid, mode, weight, choice, output ready);
endinterface

interface cdfs_rsp_if;
	import cdfs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [IDX_BITS-1:0]        entry_index;
	logic [PROB_BITS-1:0]       probability;
	logic                       found;
	logic [CNT_BITS-1:0]        entry_count;

	modport source (output valid, entry_index, probability, found, entry_count, input ready);
	modport sink   (input valid, entry_index, probability, found, entry_count, output ready);
endinterface

@@ rtl/cdf_weighted_index_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// cdf_weighted_index_sampler_unit
// Discrete sampler by inversion of a cumulative table built from loaded
// weights, with one shared restoring divider and a small sequencer.
// ----------------------------------------------------------------------------
// Load beats append weights; a finish beat turns them into per-entry
// probabilities (Q1.24) and a cumulative table whose last entry is exactly one;
// a sample beat returns the first entry whose cumulative value exceeds the
// choice. A load, or an item with an unused mode, is answered from the idle
// state. For each loaded entry a finish reads the registered weight memory and
// then runs the shared divider, which produces one quotient bit per cycle. A
// sample is a binary search over the table; each search step is a registered
// read of the cumulative memory followed by a compare. Only one item is in
// flight; a finished result sits in an output register, so the next item is
// taken as soon as that result is taken or in the same cycle.
// ----------------------------------------------------------------------------
module cdf_weighted_index_sampler_unit (
	input logic          clk,
	input logic          arst_n,
	cdfs_req_if.sink     req,
	cdfs_rsp_if.source   rsp
);
	import cdfs_pkg::*;

	state_t state_q, state_d;

	logic [CNT_BITS-1:0]    count_q, count_d;
	logic [CNT_BITS-1:0]    table_cnt_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic                   out_valid_q;

	logic [CNT_BITS-1:0]    idx_q, lo_q, hi_q;
	logic [PROB_BITS-1:0]   running_q;
	logic [REM_BITS-1:0]    rem_q;
	logic [TOTAL_BITS-1:0]  div_q;
	logic [PROB_BITS-1:0]   quo_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [FRAC_BITS-1:0]   choice_q;

	logic [IDX_BITS-1:0]    out_index_q;
	logic [PROB_BITS-1:0]   out_prob_q;
	logic                   out_found_q;
	logic [CNT_BITS-1:0]    out_count_q;

	logic [WEIGHT_BITS-1:0] weight_mem [MAX_ENTRIES];
	logic [PROB_BITS-1:0]   pick_mem   [MAX_ENTRIES];
	logic [PROB_BITS-1:0]   cum_mem    [MAX_ENTRIES];
	logic [WEIGHT_BITS-1:0] weight_rd_q;
	logic [PROB_BITS-1:0]   pick_rd_q;
	logic [PROB_BITS-1:0]   cum_rd_q;

	logic                   accept;
	logic                   full;
	logic                   weight_we;
	logic                   table_we;
	logic                   last_entry;
	logic [CNT_BITS:0]      mid_sum;
	logic [CNT_BITS-1:0]    mid;
	logic [CNT_BITS-1:0]    last_idx;
	logic [CNT_BITS-1:0]    sel;
	logic [REM_BITS-1:0]    init_a;
	logic [TOTAL_BITS-1:0]  init_d;
	logic                   init_ge;
	logic [REM_BITS-1:0]    rem_sh;
	logic                   div_ge;
	logic [PROB_BITS-1:0]   cum_wdata;
	logic                   res_load;
	logic [IDX_BITS-1:0]    res_index;
	logic [PROB_BITS-1:0]   res_prob;
	logic                   res_found;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_BITS'(MAX_ENTRIES));
	assign weight_we = accept && (req.mode == MODE_LOAD) && !full;
	assign count_d   = weight_we ? count_q + CNT_BITS'(1) : count_q;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CNT_BITS:1];
	assign last_idx = table_cnt_q - CNT_BITS'(1);
	assign sel      = (lo_q > last_idx) ? last_idx : lo_q;

	// With a zero total every entry gets floor(one / n), which is the same
	// division with a dividend of one and the entry count as divisor.
	assign init_a  = (total_q != '0) ? REM_BITS'(weight_rd_q) : REM_BITS'(1);
	assign init_d  = (total_q != '0) ? total_q : TOTAL_BITS'(count_q);
	assign init_ge = (init_a >= REM_BITS'(init_d));
	assign rem_sh  = {rem_q[REM_BITS-2:0], 1'b0};
	assign div_ge  = (rem_sh >= REM_BITS'(div_q));

	assign last_entry = (idx_q == count_q - CNT_BITS'(1));
	assign table_we   = (state_q == ST_FIN_WR);
	assign cum_wdata  = last_entry ? ONE_FIX : running_q + quo_q;

	always_comb begin
		state_d   = state_q;
		res_load  = 1'b0;
		res_index = '0;
		res_prob  = '0;
		res_found = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					unique case (req.mode)
						MODE_FINISH: begin
							if (count_q != '0) begin
								state_d  = ST_FIN_RD;
								res_load = 1'b0;
							end
						end
						MODE_SAMPLE: begin
							if (table_cnt_q != '0) begin
								state_d  = ST_SRCH;
								res_load = 1'b0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FIN_RD:   state_d = ST_FIN_INIT;
			ST_FIN_INIT: state_d = ST_FIN_DIV;
			ST_FIN_DIV: begin
				if (step_q == STEP_BITS'(FRAC_BITS - 1)) begin
					state_d = ST_FIN_WR;
				end
			end
			ST_FIN_WR: begin
				if (last_entry) begin
					state_d  = ST_IDLE;
					res_load = 1'b1;
				end else begin
					state_d = ST_FIN_RD;
				end
			end
			ST_SRCH: begin
				state_d = (lo_q < hi_q) ? ST_SRCH_CMP : ST_PICK_RD;
			end
			ST_SRCH_CMP: state_d = ST_SRCH;
			ST_PICK_RD:  state_d = ST_PICK_OUT;
			ST_PICK_OUT: begin
				state_d   = ST_IDLE;
				res_load  = 1'b1;
				res_index = sel[IDX_BITS-1:0];
				res_prob  = pick_rd_q;
				res_found = (pick_rd_q != '0);
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			table_cnt_q <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (weight_we) begin
				total_q <= total_q + TOTAL_BITS'(req.weight);
			end
			if (accept && (req.mode == MODE_FINISH)) begin
				table_cnt_q <= count_q;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_index_q <= res_index;
			out_prob_q  <= res_prob;
			out_found_q <= res_found;
			out_count_q <= count_d;
		end
		unique case (state_q)
			ST_IDLE: begin
				idx_q     <= '0;
				running_q <= '0;
				lo_q      <= '0;
				hi_q      <= table_cnt_q;
				choice_q  <= req.choice;
			end
			ST_FIN_INIT: begin
				div_q  <= init_d;
				quo_q  <= PROB_BITS'(init_ge);
				rem_q  <= init_ge ? init_a - REM_BITS'(init_d) : init_a;
				step_q <= '0;
			end
			ST_FIN_DIV: begin
				quo_q  <= {quo_q[PROB_BITS-2:0], div_ge};
				rem_q  <= div_ge ? rem_sh - REM_BITS'(div_q) : rem_sh;
				step_q <= step_q + STEP_BITS'(1);
			end
			ST_FIN_WR: begin
				running_q <= running_q + quo_q;
				idx_q     <= idx_q + CNT_BITS'(1);
			end
			ST_SRCH_CMP: begin
				if (cum_rd_q > PROB_BITS'(choice_q)) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + CNT_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[count_q[IDX_BITS-1:0]] <= req.weight;
		end
		weight_rd_q <= weight_mem[idx_q[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (table_we) begin
			pick_mem[idx_q[IDX_BITS-1:0]] <= quo_q;
		end
		pick_rd_q <= pick_mem[sel[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (table_we) begin
			cum_mem[idx_q[IDX_BITS-1:0]] <= cum_wdata;
		end
		cum_rd_q <= cum_mem[mid[IDX_BITS-1:0]];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_index = out_index_q;
	assign rsp.probability = out_prob_q;
	assign rsp.found       = out_found_q;
	assign rsp.entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ENTRIES))
		else $error("loaded count beyond store depth");

	a_table_within_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		table_cnt_q <= count_q)
		else $error("table covers more entries than were loaded");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_DIV) |-> (rem_q < REM_BITS'(div_q)))
		else $error("divider remainder not below divisor");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q) && (hi_q <= table_cnt_q))
		else $error("search bounds out of order");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q) |-> (out_prob_q != '0))
		else $error("found result with zero probability");

endmodule
